FILE: design/protobuf_wire_tokenizer_core_macros.svh
// assertion macros shared by the tokenizer modules
// no dependencies; included by the files that carry assertions
`ifndef PROTOBUF_WIRE_TOKENIZER_CORE_MACROS_SVH
`define PROTOBUF_WIRE_TOKENIZER_CORE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PWT_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define PWT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PWT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/pwt_pkg.sv
// types and constants of the protobuf wire tokenizer
// no dependencies; imported by every tokenizer module
package pwt_pkg;

	// result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// wire types
	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LEN     = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	// varint limit and fixed payload lengths
	localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
	localparam logic [7:0] FIXED64_LEN      = 8'd8;
	localparam logic [7:0] FIXED32_LEN      = 8'd4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       msg_last;
	} pwt_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] field_number;
		logic [2:0]  wire_type;
		logic [63:0] value;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic        msg_end;
	} pwt_out_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [6:0] bits7;
		logic       cont;
		logic       last;
	} pwt_tok_t;

endpackage

FILE: design/pwt_front.sv
// front stage: accepts message bytes and classifies them into tokens
// depends on pwt_pkg
module pwt_front import pwt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pwt_in_t  in_data,
	output logic     push,
	output pwt_tok_t push_tok,
	input  logic     q_full
);

	logic     v_s1;
	pwt_tok_t tok_s1;

	// stage register moves on whenever it is empty or the queue has room
	assign push     = v_s1 && !q_full;
	assign in_ready = !v_s1 || !q_full;
	assign push_tok = tok_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// split byte into varint payload bits and continuation flag
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tok_s1.bits7 <= in_data.in_byte[6:0];
			tok_s1.cont  <= in_data.in_byte[7];
			tok_s1.last  <= in_data.msg_last;
		end
	end

endmodule

FILE: design/pwt_queue.sv
// token queue between the front stage and the decoder
// depends on pwt_pkg and the assertion macros header
`include "protobuf_wire_tokenizer_core_macros.svh"
module pwt_queue import pwt_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pwt_tok_t push_tok,
	output logic     full,
	input  logic     pop,
	output logic     q_valid,
	output pwt_tok_t q_tok
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	pwt_tok_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_tok   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PWT_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "queue count overflow")
	`PWT_ASSERT_IMPL(a_no_push_full, clk, arst_n, push, !full, "push into full queue")
	`PWT_ASSERT_IMPL(a_empty_ptrs, clk, arst_n, count_q == '0, wr_ptr_q == rd_ptr_q, "pointers apart on empty")

endmodule

FILE: design/pwt_back.sv
// decoder: varint assembly, field state machine and result register
// depends on pwt_pkg and the assertion macros header
`include "protobuf_wire_tokenizer_core_macros.svh"
module pwt_back import pwt_pkg::*; #(
	parameter int LENGTH_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     tok_valid,
	input  pwt_tok_t tok,
	output logic     tok_pop,
	output logic     out_valid,
	input  logic     out_ready,
	output pwt_out_t out_data
);

	typedef enum logic [1:0] {
		PH_TAG,
		PH_VALUE,
		PH_LEN,
		PH_PAYLOAD
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic [63:0]            acc_q, acc_n;
	logic [3:0]             vb_q, vb_n;
	logic [31:0]            field_q, field_n;
	logic [2:0]             wire_q, wire_n;
	logic [LENGTH_BITS-1:0] left_q, left_n;
	logic                   err_q, err_n;
	logic                   out_valid_q;
	pwt_out_t               out_q;

	pwt_out_t    res;
	logic        have;
	logic        err;
	logic [5:0]  sh;
	logic [63:0] acc_or;
	logic [7:0]  raw;

	assign tok_pop   = tok_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sh     = 6'(7'(vb_q) * 7'd7);
	assign acc_or = acc_q | (64'(tok.bits7) << sh);
	assign raw    = {tok.cont, tok.bits7};

	// next state and result for the token at the head of the queue
	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		vb_n    = vb_q;
		field_n = field_q;
		wire_n  = wire_q;
		left_n  = left_q;
		err_n   = err_q;
		res     = '0;
		have    = 1'b0;
		err     = 1'b0;

		if (err_q) begin
			// bytes after an error are dropped until the message ends
		end else if (phase_q == PH_PAYLOAD) begin
			res.kind         = KIND_PAYLOAD;
			res.field_number = field_q;
			res.wire_type    = wire_q;
			res.payload_byte = raw;
			left_n           = left_q - 1'b1;
			have             = 1'b1;
			if (left_q == LENGTH_BITS'(1)) begin
				res.payload_last = 1'b1;
				phase_n          = PH_TAG;
			end
		end else begin
			acc_n = acc_or;
			vb_n  = vb_q + 1'b1;
			if (tok.cont) begin
				if (vb_n >= VARINT_MAX_BYTES) begin
					err = 1'b1;
				end
			end else begin
				acc_n = '0;
				vb_n  = '0;
				unique case (phase_q)
					PH_TAG: begin
						field_n = acc_or[34:3];
						wire_n  = acc_or[2:0];
						res.field_number = acc_or[34:3];
						res.wire_type    = acc_or[2:0];
						unique case (acc_or[2:0])
							WT_VARINT: phase_n = PH_VALUE;
							WT_LEN:    phase_n = PH_LEN;
							WT_FIXED64: begin
								left_n    = LENGTH_BITS'(FIXED64_LEN);
								phase_n   = PH_PAYLOAD;
								res.value = 64'(FIXED64_LEN);
								have      = 1'b1;
							end
							WT_FIXED32: begin
								left_n    = LENGTH_BITS'(FIXED32_LEN);
								phase_n   = PH_PAYLOAD;
								res.value = 64'(FIXED32_LEN);
								have      = 1'b1;
							end
							default: err = 1'b1;
						endcase
					end
					PH_VALUE: begin
						res.field_number = field_q;
						res.wire_type    = wire_q;
						res.value        = acc_or;
						phase_n          = PH_TAG;
						have             = 1'b1;
					end
					default: begin
						// length varint
						if ((LENGTH_BITS < 64) && ((acc_or >> LENGTH_BITS) != '0)) begin
							err = 1'b1;
						end else begin
							res.field_number = field_q;
							res.wire_type    = wire_q;
							res.value        = acc_or;
							have             = 1'b1;
							if (acc_or == '0) begin
								phase_n = PH_TAG;
							end else begin
								left_n  = acc_or[LENGTH_BITS-1:0];
								phase_n = PH_PAYLOAD;
							end
						end
					end
				endcase
			end
		end

		// message ending inside a field
		if (!err_q && tok.last && !err && (phase_n != PH_TAG || vb_n != '0)) begin
			err = 1'b1;
		end

		if (err) begin
			res      = '0;
			res.kind = KIND_ERROR;
			err_n    = 1'b1;
			have     = 1'b1;
		end

		// final byte: always one result, then back to reset state
		if (tok.last) begin
			if (err_q) begin
				res.kind = KIND_ERROR;
			end
			res.msg_end = 1'b1;
			have        = 1'b1;
			phase_n     = PH_TAG;
			acc_n       = '0;
			vb_n        = '0;
			field_n     = '0;
			wire_n      = '0;
			left_n      = '0;
			err_n       = 1'b0;
		end
	end

	// decoder state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TAG;
			acc_q       <= '0;
			vb_q        <= '0;
			field_q     <= '0;
			wire_q      <= '0;
			left_q      <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (tok_pop) begin
			phase_q     <= phase_n;
			acc_q       <= acc_n;
			vb_q        <= vb_n;
			field_q     <= field_n;
			wire_q      <= wire_n;
			left_q      <= left_n;
			err_q       <= err_n;
			out_valid_q <= have;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (tok_pop) begin
			out_q <= res;
		end
	end

	`PWT_ASSERT_ALWAYS(a_vb_bound, clk, arst_n, vb_q <= VARINT_MAX_BYTES, "varint byte count past limit")
	`PWT_ASSERT_NEXT(a_last_result, clk, arst_n, tok_pop && tok.last, out_valid_q && out_q.msg_end, "final byte gave no result")
	`PWT_ASSERT_NEXT(a_last_clears, clk, arst_n, tok_pop && tok.last, phase_q == PH_TAG && !err_q && vb_q == '0, "state not cleared at message end")
	`PWT_ASSERT_IMPL(a_plast_kind, clk, arst_n, out_valid_q && out_q.payload_last, out_q.kind == KIND_PAYLOAD, "payload_last on non-payload result")

endmodule

FILE: design/protobuf_wire_tokenizer_core.sv
// top level of the protobuf wire tokenizer: front stage, token queue, decoder
// depends on pwt_pkg, pwt_front, pwt_queue and pwt_back
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_ready | in_data  (pwt_in_t: in_byte, msg_last)
//  out     | output    | out_valid/out_ready | out_data (pwt_out_t: header, payload, error)
//
// one byte per cycle while out_ready is high; path: stage register, queue, result register
// the decoder state (varint accumulator, phase, length counter) updates once per byte
// arst_n clears the stage valid, queue pointers, decoder state and result valid
// the queue of QUEUE_DEPTH tokens lets the front keep accepting while the output stalls
// bytes that yield no result still pass through the decoder at one per cycle unless the output stalls
module protobuf_wire_tokenizer_core import pwt_pkg::*; #(
	parameter int LENGTH_BITS = 32,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pwt_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output pwt_out_t out_data
);

	logic     push;
	pwt_tok_t push_tok;
	logic     q_full;
	logic     pop;
	logic     q_valid;
	pwt_tok_t q_tok;

	// accept and classify
	pwt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.push     (push),
		.push_tok (push_tok),
		.q_full   (q_full)
	);

	// decoupling queue
	pwt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_tok    (q_tok)
	);

	// decode and hold results
	pwt_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (q_valid),
		.tok       (q_tok),
		.tok_pop   (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
